>>> hdl/assert_macros.svh
// assertion macros used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/ddo_pkg.sv
// types, constants and tables for the differential drive odometry block
`default_nettype none

package ddo_pkg;

	localparam int TW_W   = 25;
	localparam int ACC_W  = 76;
	localparam int MAG_W  = 64;
	localparam int BMAG_W = 34;
	localparam int CW     = 34;

	localparam int MUL_BITS = 34;
	localparam int DIV_BITS = 64;

	localparam logic signed [34:0] TURN_PER_RADIAN = 35'sd683565276;
	localparam logic signed [34:0] Q30_ONE_B       = 35'sd1073741824;
	localparam logic signed [33:0] Q30_ONE         = 34'sd1073741824;
	localparam logic signed [33:0] Q31_ONE         = 34'sd2147483648;
	localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;

	typedef struct packed {
		logic signed [31:0] left_distance;
		logic signed [31:0] right_distance;
	} wheel_t;

	typedef struct packed {
		logic signed [31:0] pose_x;
		logic signed [31:0] pose_y;
		logic signed [31:0] pose_heading;
	} pose_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SETUP,
		S_MUL,
		S_DIV,
		S_FIX,
		S_CORD,
		S_DONE
	} state_t;

	typedef enum logic [3:0] {
		P_TURN_MUL,
		P_TURN_DIV,
		P_SL_MUL,
		P_SL_DIV,
		P_LR_MUL,
		P_LR_DIV,
		P_CORD_T,
		P_FWD_MUL,
		P_LFT_MUL,
		P_CORD_H,
		P_X1,
		P_X2,
		P_Y1,
		P_Y2
	} step_t;

	// atan(2^-i) as binary angle
	function automatic logic [29:0] atan_entry(input logic [4:0] idx);
		logic [29:0] v;
		case (idx)
			5'd0:  v = 30'h20000000;
			5'd1:  v = 30'h12E4051E;
			5'd2:  v = 30'h09FB385B;
			5'd3:  v = 30'h051111D4;
			5'd4:  v = 30'h028B0D43;
			5'd5:  v = 30'h0145D7E1;
			5'd6:  v = 30'h00A2F61E;
			5'd7:  v = 30'h00517C55;
			5'd8:  v = 30'h0028BE53;
			5'd9:  v = 30'h00145F2F;
			5'd10: v = 30'h000A2F98;
			5'd11: v = 30'h000517CC;
			5'd12: v = 30'h00028BE6;
			5'd13: v = 30'h000145F3;
			5'd14: v = 30'h0000A2F9;
			5'd15: v = 30'h0000517C;
			5'd16: v = 30'h000028BE;
			5'd17: v = 30'h0000145F;
			5'd18: v = 30'h00000A2F;
			5'd19: v = 30'h00000517;
			5'd20: v = 30'h0000028B;
			5'd21: v = 30'h00000145;
			5'd22: v = 30'h000000A2;
			5'd23: v = 30'h00000051;
			5'd24: v = 30'h00000028;
			5'd25: v = 30'h00000014;
			5'd26: v = 30'h0000000A;
			5'd27: v = 30'h00000005;
			5'd28: v = 30'h00000002;
			5'd29: v = 30'h00000001;
			default: v = 30'h00000000;
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
		logic signed [31:0] r;
		if (v > 50'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -50'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hdl/differential_drive_odometry.sv
// dead reckoning for a two-wheel base: pose update from wheel distances
// throughput: one request at a time; the next is taken once the result is registered
// cycle count is set by the one serial add/subtract unit (one bit per cycle) and the cordic
// reset: pose and heading clear to zero, track width to one meter, no result pending
`default_nettype none

`include "assert_macros.svh"

module differential_drive_odometry import ddo_pkg::*; #(
	parameter int FRAC_BITS    = 16,
	parameter int CORDIC_STEPS = 24
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wheel_valid,
	output      logic           wheel_stall,
	input  wire wheel_t         wheel,
	output      logic           pose_valid,
	input  wire logic           pose_stall,
	output      pose_t          pose,
	input  wire logic           cfg_we,
	input  wire logic [TW_W-1:0] cfg_wdata
);

	localparam logic [TW_W-1:0] TW_RESET  = TW_W'(1) << FRAC_BITS;
	localparam logic [5:0]      MUL_LAST  = 6'(MUL_BITS - 1);
	localparam logic [5:0]      DIV_LAST  = 6'(DIV_BITS - 1);
	localparam logic [5:0]      CORD_LAST = 6'(CORDIC_STEPS - 1);

	state_t state_q, state_d;
	step_t  step_q, step_d;
	logic [5:0] cnt_q, cnt_d;

	logic [TW_W-1:0] w_q;
	logic [TW_W-1:0] w_eff;
	logic signed [31:0] px_q, py_q;
	logic [31:0] hd_q;
	logic pose_valid_q;
	pose_t pose_q;

	logic signed [32:0] diff_q, sum_q;
	logic signed [64:0] tmp_q;
	logic [31:0] theta_q;
	logic signed [47:0] fwd_q, lft_q;
	logic signed [33:0] s_q, c_q;
	logic signed [49:0] pacc_q;
	logic [ACC_W-1:0] opa_q, acc_q;
	logic [MAG_W-1:0] opb_q;
	logic neg_q;
	logic signed [CW-1:0] cx_q, cy_q, cz_q;
	logic flip_q;

	// operand selection
	logic signed [64:0] a_val, a_abs;
	logic signed [34:0] b_val, b_abs;
	logic step_div, step_cord;
	logic [MAG_W-1:0] mag_a;
	logic [BMAG_W-1:0] mag_b;

	// shared adder
	logic [ACC_W-1:0] add_x, add_y, add_sum, fix_mag;
	logic add_cin;
	logic [34:0] div_t;
	logic div_fits;
	logic signed [ACC_W-1:0] res;
	logic signed [45:0] res_hi;
	logic small_turn;

	// cordic step
	logic signed [CW-1:0] cdx, cdy, cat, nx, ny, nz, z0;
	logic [31:0] cord_angle;
	logic load_out, accept;

	assign w_eff = (w_q == '0) ? TW_W'(1) : w_q;
	assign accept = wheel_valid && (state_q == S_IDLE);
	assign wheel_stall = (state_q != S_IDLE);
	assign pose_valid = pose_valid_q;
	assign pose = pose_q;

	always_comb begin
		step_div  = 1'b0;
		step_cord = 1'b0;
		a_val = '0;
		b_val = '0;
		case (step_q)
			P_TURN_MUL: begin
				a_val = 65'(diff_q);
				b_val = TURN_PER_RADIAN;
			end
			P_TURN_DIV: begin
				step_div = 1'b1;
				a_val = tmp_q;
				b_val = signed'({10'b0, w_eff});
			end
			P_SL_MUL: begin
				a_val = 65'(sum_q);
				b_val = 35'(diff_q);
			end
			P_SL_DIV: begin
				step_div = 1'b1;
				a_val = tmp_q;
				b_val = signed'({8'b0, w_eff, 2'b00});
			end
			P_LR_MUL: begin
				a_val = 65'(sum_q);
				b_val = signed'({10'b0, w_eff});
			end
			P_LR_DIV: begin
				step_div = 1'b1;
				a_val = tmp_q;
				b_val = signed'({diff_q[32], diff_q, 1'b0});
			end
			P_FWD_MUL: begin
				a_val = tmp_q;
				b_val = 35'(s_q);
			end
			P_LFT_MUL: begin
				a_val = tmp_q;
				b_val = Q30_ONE_B - 35'(c_q);
			end
			P_X1: begin
				a_val = 65'(fwd_q);
				b_val = 35'(c_q);
			end
			P_X2: begin
				a_val = 65'(lft_q);
				b_val = 35'(s_q);
			end
			P_Y1: begin
				a_val = 65'(fwd_q);
				b_val = 35'(s_q);
			end
			P_Y2: begin
				a_val = 65'(lft_q);
				b_val = 35'(c_q);
			end
			P_CORD_T, P_CORD_H: begin
				step_cord = 1'b1;
			end
			default: begin
				step_cord = 1'b0;
			end
		endcase
		a_abs = a_val[64] ? -a_val : a_val;
		b_abs = b_val[34] ? -b_val : b_val;
		mag_a = a_abs[MAG_W-1:0];
		mag_b = b_abs[BMAG_W-1:0];
	end

	// one add/subtract unit serves multiply, divide and sign fix
	always_comb begin
		div_t   = {acc_q[33:0], opb_q[MAG_W-1]};
		fix_mag = step_div ? {12'b0, opb_q} : acc_q;
		add_x   = '0;
		add_y   = '0;
		add_cin = 1'b0;
		case (state_q)
			S_MUL: begin
				add_x = acc_q;
				add_y = opb_q[0] ? opa_q : '0;
			end
			S_DIV: begin
				add_x   = {41'b0, div_t};
				add_y   = ~{42'b0, opa_q[33:0]};
				add_cin = 1'b1;
			end
			S_FIX: begin
				add_x   = neg_q ? ~fix_mag : fix_mag;
				add_cin = neg_q;
			end
			default: begin
				add_x = '0;
			end
		endcase
		add_sum  = add_x + add_y + ACC_W'(add_cin);
		div_fits = !add_sum[ACC_W-1];
		res      = signed'(add_sum);
		res_hi   = res[75:30];
		small_turn = (res[75:20] == '0) ||
			((res[75:20] == '1) && (res[19:0] != '0));
	end

	always_comb begin
		cord_angle = (step_q == P_CORD_T) ? theta_q : hd_q;
		z0  = 34'(signed'(cord_angle));
		cdx = cy_q >>> cnt_q[4:0];
		cdy = cx_q >>> cnt_q[4:0];
		cat = signed'({4'b0, atan_entry(cnt_q[4:0])});
		if (!cz_q[CW-1]) begin
			nx = cx_q - cdx;
			ny = cy_q + cdy;
			nz = cz_q - cat;
		end else begin
			nx = cx_q + cdx;
			ny = cy_q - cdy;
			nz = cz_q + cat;
		end
	end

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		cnt_d    = cnt_q;
		load_out = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (wheel_valid) begin
					state_d = S_SETUP;
					step_d  = P_TURN_MUL;
				end
			end
			S_SETUP: begin
				cnt_d = '0;
				if (step_cord)
					state_d = S_CORD;
				else if (step_div)
					state_d = S_DIV;
				else
					state_d = S_MUL;
			end
			S_MUL: begin
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == MUL_LAST)
					state_d = S_FIX;
			end
			S_DIV: begin
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == DIV_LAST)
					state_d = S_FIX;
			end
			S_CORD: begin
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == CORD_LAST) begin
					state_d = S_SETUP;
					step_d  = (step_q == P_CORD_T) ? P_FWD_MUL : P_X1;
				end
			end
			S_FIX: begin
				state_d = S_SETUP;
				case (step_q)
					P_TURN_MUL: step_d = P_TURN_DIV;
					P_TURN_DIV: step_d = small_turn ? P_SL_MUL : P_LR_MUL;
					P_SL_MUL:   step_d = P_SL_DIV;
					P_SL_DIV:   step_d = P_CORD_H;
					P_LR_MUL:   step_d = P_LR_DIV;
					P_LR_DIV:   step_d = P_CORD_T;
					P_FWD_MUL:  step_d = P_LFT_MUL;
					P_LFT_MUL:  step_d = P_CORD_H;
					P_X1:       step_d = P_X2;
					P_X2:       step_d = P_Y1;
					P_Y1:       step_d = P_Y2;
					P_Y2:       state_d = S_DONE;
					default:    state_d = S_IDLE;
				endcase
			end
			S_DONE: begin
				if (!pose_valid_q || !pose_stall) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			step_q       <= P_TURN_MUL;
			cnt_q        <= '0;
			w_q          <= TW_RESET;
			px_q         <= '0;
			py_q         <= '0;
			hd_q         <= '0;
			pose_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			cnt_q   <= cnt_d;
			if (cfg_we)
				w_q <= cfg_wdata;
			if (state_q == S_FIX && step_q == P_X2)
				px_q <= sat32(pacc_q - 50'(res_hi));
			if (state_q == S_FIX && step_q == P_Y2)
				py_q <= sat32(pacc_q + 50'(res_hi));
			if (load_out) begin
				hd_q         <= hd_q + theta_q;
				pose_valid_q <= 1'b1;
			end else if (!pose_stall) begin
				pose_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			diff_q <= 33'(wheel.right_distance) - 33'(wheel.left_distance);
			sum_q  <= 33'(wheel.right_distance) + 33'(wheel.left_distance);
		end
		if (load_out)
			pose_q <= '{pose_x: px_q, pose_y: py_q, pose_heading: hd_q + theta_q};
		case (state_q)
			S_SETUP: begin
				neg_q <= a_val[64] ^ b_val[34];
				acc_q <= '0;
				if (step_div) begin
					opb_q <= mag_a;
					opa_q <= {42'b0, mag_b};
				end else begin
					opa_q <= {12'b0, mag_a};
					opb_q <= {30'b0, mag_b};
				end
				cx_q <= CORDIC_GAIN_INV;
				cy_q <= '0;
				// fold the angle into the right half plane
				if (z0 > Q30_ONE) begin
					cz_q   <= z0 - Q31_ONE;
					flip_q <= 1'b1;
				end else if (z0 < -Q30_ONE) begin
					cz_q   <= z0 + Q31_ONE;
					flip_q <= 1'b1;
				end else begin
					cz_q   <= z0;
					flip_q <= 1'b0;
				end
			end
			S_MUL: begin
				acc_q <= add_sum;
				opa_q <= opa_q << 1;
				opb_q <= opb_q >> 1;
			end
			S_DIV: begin
				acc_q <= {42'b0, div_fits ? add_sum[33:0] : div_t[33:0]};
				opb_q <= {opb_q[MAG_W-2:0], div_fits};
			end
			S_CORD: begin
				cx_q <= nx;
				cy_q <= ny;
				cz_q <= nz;
				if (cnt_q == CORD_LAST) begin
					s_q <= flip_q ? -ny : ny;
					c_q <= flip_q ? -nx : nx;
				end
			end
			S_FIX: begin
				case (step_q)
					P_TURN_MUL, P_SL_MUL, P_LR_MUL, P_LR_DIV: tmp_q <= res[64:0];
					P_TURN_DIV: begin
						theta_q <= res[31:0];
						if (small_turn)
							fwd_q <= 48'(sum_q >>> 1);
					end
					P_SL_DIV:  lft_q  <= res[47:0];
					P_FWD_MUL: fwd_q  <= 48'(res_hi);
					P_LFT_MUL: lft_q  <= 48'(res_hi);
					P_X1:      pacc_q <= 50'(px_q) + 50'(res_hi);
					P_Y1:      pacc_q <= 50'(py_q) + 50'(res_hi);
					default: begin
						pacc_q <= pacc_q;
					end
				endcase
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	`ASSERT_NEXT(a_take_starts, clk, arst_n, accept, state_q == S_SETUP && step_q == P_TURN_MUL, "request not started")
	`ASSERT_NEXT(a_out_src, clk, arst_n, !pose_valid && state_q != S_DONE, !pose_valid, "result without finished request")
	`ASSERT_IMPLIES(a_cord_idx, clk, arst_n, state_q == S_CORD, cnt_q <= CORD_LAST, "cordic index out of range")

endmodule

`default_nettype wire

>>> test/differential_drive_odometry_test.sv
// self-checking testbench for the differential drive odometry block
`default_nettype none

module differential_drive_odometry_test import ddo_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam longint LIMIT_CYCLES = 6000000;
	localparam longint ARC_CONST    = 64'sd683565276;
	localparam longint TURN_SMALL   = 64'sd1048576;
	localparam longint ONE_Q30      = 64'sd1073741824;
	localparam longint KGAIN        = 64'sd652032874;
	localparam int     SPIN_STEPS   = 24;
	localparam int     DRAIN_WAIT   = 600;

	// odometry predictor and queue of expected poses
	class pose_board;
		logic [TW_W-1:0] track;
		logic signed [31:0] px, py;
		logic [31:0] hd;
		pose_t pending[$];
		int errors;
		longint angle_tab[30] = '{
			'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
			'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
			'h00028BE6, 'h000145F3, 'h0000A2F9, 'h0000517C, 'h000028BE, 'h0000145F,
			'h00000A2F, 'h00000517, 'h0000028B, 'h00000145, 'h000000A2, 'h00000051,
			'h00000028, 'h00000014, 'h0000000A, 'h00000005, 'h00000002, 'h00000001};

		function new();
			track = 25'd65536;
			px = 0;
			py = 0;
			hd = 0;
			errors = 0;
		endfunction

		// floor(a * s / 2^30), split to stay inside 64 bits
		function longint scale_q30(longint a, longint s);
			longint hi, lo;
			hi = a >>> 15;
			lo = a & 64'sh7fff;
			return (hi * s + ((lo * s) >>> 15)) >>> 15;
		endfunction

		function void rotate(input logic [31:0] ang, output longint s, output longint c);
			longint z, x, y, dx, dy;
			bit flip;
			z = longint'($signed(ang));
			x = KGAIN;
			y = 0;
			flip = 0;
			if (z > ONE_Q30) begin
				z -= 2 * ONE_Q30;
				flip = 1;
			end else if (z < -ONE_Q30) begin
				z += 2 * ONE_Q30;
				flip = 1;
			end
			for (int i = 0; i < SPIN_STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx;
					y += dy;
					z -= angle_tab[i];
				end else begin
					x += dx;
					y -= dy;
					z += angle_tab[i];
				end
			end
			s = flip ? -y : y;
			c = flip ? -x : x;
		endfunction

		function logic signed [31:0] clamp32(longint v);
			if (v > 64'sd2147483647)
				return 32'sh7fffffff;
			if (v < -64'sd2147483648)
				return 32'sh80000000;
			return v[31:0];
		endfunction

		function void note_wheel(wheel_t wh);
			longint dl, dr, wv, diff, sum, turn, fwd, lft, r, st, ct, sh, ch;
			logic [31:0] theta;
			pose_t p;
			dl = longint'(wh.left_distance);
			dr = longint'(wh.right_distance);
			wv = (track == 0) ? 64'sd1 : longint'({39'd0, track});
			diff = dr - dl;
			sum = dr + dl;
			turn = diff * ARC_CONST / wv;
			theta = turn[31:0];
			if (turn < TURN_SMALL && turn > -TURN_SMALL) begin
				fwd = sum >>> 1;
				lft = sum * diff / (4 * wv);
			end else begin
				r = sum * wv / (2 * diff);
				rotate(theta, st, ct);
				fwd = scale_q30(r, st);
				lft = scale_q30(r, ONE_Q30 - ct);
			end
			rotate(hd, sh, ch);
			px = clamp32(longint'(px) + scale_q30(fwd, ch) - scale_q30(lft, sh));
			py = clamp32(longint'(py) + scale_q30(fwd, sh) + scale_q30(lft, ch));
			hd = hd + theta;
			p.pose_x = px;
			p.pose_y = py;
			p.pose_heading = hd;
			pending.push_back(p);
		endfunction

		function void check_pose(pose_t got);
			pose_t exp_p;
			if (pending.size() == 0) begin
				$error("unexpected pose x=%h y=%h heading=%h",
					got.pose_x, got.pose_y, got.pose_heading);
				errors++;
				return;
			end
			exp_p = pending.pop_front();
			if (got.pose_x !== exp_p.pose_x) begin
				$error("pose_x expected %h actual %h", exp_p.pose_x, got.pose_x);
				errors++;
			end
			if (got.pose_y !== exp_p.pose_y) begin
				$error("pose_y expected %h actual %h", exp_p.pose_y, got.pose_y);
				errors++;
			end
			if (got.pose_heading !== exp_p.pose_heading) begin
				$error("pose_heading expected %h actual %h",
					exp_p.pose_heading, got.pose_heading);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic wheel_valid = 0;
	logic wheel_stall;
	wheel_t wheel = '0;
	logic pose_valid;
	logic pose_stall = 0;
	pose_t pose;
	logic cfg_we = 0;
	logic [TW_W-1:0] cfg_wdata = '0;

	pose_board board = new();
	bit in_idle_on = 1;
	bit out_idle_on = 1;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	longint cycles = 0;

	differential_drive_odometry u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.wheel_valid(wheel_valid),
		.wheel_stall(wheel_stall),
		.wheel      (wheel),
		.pose_valid (pose_valid),
		.pose_stall (pose_stall),
		.pose       (pose),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// receiver: random stalls plus a long hold-off each time hold_req is bumped
	always @(negedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = 2000;
		end
		if (hold_left > 0) begin
			hold_left--;
			pose_stall <= 1'b1;
		end else begin
			pose_stall <= out_idle_on && ($urandom_range(99) < 13);
		end
	end

	always @(posedge clk) begin
		if (arst_n && pose_valid && !pose_stall)
			board.check_pose(pose);
	end

	task automatic send_wheel(input logic [31:0] l, input logic [31:0] r);
		@(negedge clk);
		while (in_idle_on && $urandom_range(99) < 13) begin
			wheel_valid <= 1'b0;
			@(negedge clk);
		end
		wheel_valid <= 1'b1;
		wheel.left_distance <= l;
		wheel.right_distance <= r;
		do @(posedge clk); while (wheel_stall);
		board.note_wheel('{left_distance: l, right_distance: r});
	endtask

	task automatic drain();
		@(negedge clk);
		wheel_valid <= 1'b0;
		wait (board.pending.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic set_track(input logic [TW_W-1:0] v);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		board.track = v;
	endtask

	task automatic random_wheel();
		logic [31:0] l, r, d;
		int kind;
		kind = $urandom_range(9);
		l = $urandom;
		r = $urandom;
		d = $urandom_range(4095) - 2048;
		case (kind)
			0, 1: begin
				l = $signed(l) >>> 12;
				r = l + d;
			end
			2: r = l;
			3: begin
				l = $signed(l) >>> 8;
				r = -l;
			end
			4, 5: begin
				l = $signed(l) >>> 14;
				r = $signed(r) >>> 14;
			end
			6: begin
				l = $signed(l) >>> $urandom_range(20);
				r = l + ($signed(r) >>> $urandom_range(31));
			end
			default: ;
		endcase
		send_wheel(l, r);
	endtask

	task automatic directed_wheels();
		send_wheel(32'h0, 32'h0);
		send_wheel(32'h0001_0000, 32'h0001_0000);
		send_wheel(32'h7fff_ffff, 32'h7fff_ffff);
		send_wheel(32'h7fff_ffff, 32'h7fff_ffff);
		send_wheel(32'h8000_0000, 32'h8000_0000);
		send_wheel(32'h8000_0000, 32'h7fff_ffff);
		send_wheel(32'h7fff_ffff, 32'h8000_0000);
		send_wheel(32'h0000_0100, 32'h0000_0110);
		send_wheel(32'hffff_0000, 32'h0001_0000);
		send_wheel(32'h0002_0000, 32'h0000_0000);
		send_wheel(32'h0003_243f, 32'hfffc_dbc1);
		send_wheel(32'h0000_0000, 32'h0006_487f);
		send_wheel(32'h8000_0000, 32'h0);
		send_wheel(32'hffff_ffff, 32'h0000_0001);
		send_wheel(32'h1234_5678, 32'hedcb_a987);
		send_wheel(32'h0010_0000, 32'h0010_0400);
		send_wheel(32'hfff0_0000, 32'hffef_f000);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed_wheels();
		repeat (250) random_wheel();

		set_track(25'd655);
		directed_wheels();
		hold_req++;
		repeat (200) random_wheel();

		set_track(25'd16777216);
		in_idle_on = 0;
		out_idle_on = 0;
		directed_wheels();
		repeat (250) random_wheel();
		in_idle_on = 1;
		out_idle_on = 1;

		set_track(25'd0);
		repeat (150) random_wheel();
		drain();
		repeat (100) random_wheel();

		set_track(25'h1ff_ffff);
		directed_wheels();
		repeat (200) random_wheel();

		set_track(25'd65536);
		repeat (150) random_wheel();

		for (int k = 0; k < 3; k++) begin
			set_track(TW_W'($urandom_range(16777216, 655)));
			repeat (100) random_wheel();
		end
		drain();

		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
